/* rtl/gbe_pkg.sv */
// Shared types and constants of the glyph bitmap expander.
package gbe_pkg;

    localparam int COORD_BITS  = 16;
    localparam int COLOR_BITS  = 32;
    localparam int BYTE_BITS   = 8;
    localparam int COUNT_BITS  = $clog2(BYTE_BITS + 1);
    localparam int AREA_BITS   = 2 * BYTE_BITS;
    localparam int QUEUE_DEPTH = 4;
    localparam int DATA_BITS   = 32;
    localparam int ADDR_BITS   = 3;

    // register indexes (byte address / 4)
    localparam logic [0:0] REG_BASELINE = 1'b0;

    typedef logic [COORD_BITS-1:0] t_coord;
    typedef logic [COLOR_BITS-1:0] t_color;
    typedef logic [BYTE_BITS-1:0]  t_byte;
    typedef logic [COUNT_BITS-1:0] t_count;

    typedef enum logic {
        OP_HEADER = 1'b0,
        OP_BITMAP = 1'b1
    } t_op;

    typedef enum logic {
        KIND_PIXEL = 1'b0,
        KIND_DONE  = 1'b1
    } t_kind;

    typedef enum logic [1:0] {
        CMD_HEAD  = 2'd0,
        CMD_EMPTY = 2'd1,
        CMD_BYTE  = 2'd2
    } t_cmd_kind;

    typedef struct packed {
        t_op               operation;
        t_coord            pen_x;
        t_coord            pen_y;
        t_byte             glyph_width;
        t_byte             glyph_height;
        logic signed [7:0] offset_x;
        logic signed [7:0] offset_y;
        t_byte             advance;
        t_color            ink_color;
        t_byte             bitmap_byte;
    } t_in_word;

    typedef struct packed {
        t_kind  kind;
        t_coord pixel_x;
        t_coord pixel_y;
        t_color pixel_value;
        t_coord next_pen_x;
        logic   last;
    } t_out_word;

    // classified work handed from front to back
    typedef struct packed {
        t_cmd_kind         kind;
        t_coord            pen_x;
        t_coord            pen_y;
        t_byte             width;
        logic signed [7:0] off_x;
        logic signed [7:0] off_y;
        t_byte             advance;
        t_color            color;
        t_byte             bits;
        t_count            count;
        logic              final_byte;
    } t_cmd;

endpackage

/* rtl/gbe_front.sv */
// Front end: accepts input words, tracks glyph pixel budget, classifies work.
module gbe_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  gbe_pkg::t_in_word i_in_word,
    output logic              o_push,
    output gbe_pkg::t_cmd     o_cmd,
    input  logic              i_full
);

    logic                            r_active;
    logic [gbe_pkg::AREA_BITS-1:0]   r_remaining;
    logic                            n_active;
    logic [gbe_pkg::AREA_BITS-1:0]   n_remaining;
    logic [gbe_pkg::AREA_BITS-1:0]   w_area;
    logic                            w_accept;
    gbe_pkg::t_count                 w_count;

    assign o_in_ready = !i_full;
    assign w_accept   = i_in_valid && !i_full;
    assign w_area     = {{gbe_pkg::BYTE_BITS{1'b0}}, i_in_word.glyph_width}
                      * {{gbe_pkg::BYTE_BITS{1'b0}}, i_in_word.glyph_height};

    always_comb begin
        n_active          = r_active;
        n_remaining       = r_remaining;
        o_push            = 1'b0;
        w_count           = gbe_pkg::t_count'(gbe_pkg::BYTE_BITS);
        o_cmd.kind        = gbe_pkg::CMD_BYTE;
        o_cmd.pen_x       = i_in_word.pen_x;
        o_cmd.pen_y       = i_in_word.pen_y;
        o_cmd.width       = i_in_word.glyph_width;
        o_cmd.off_x       = i_in_word.offset_x;
        o_cmd.off_y       = i_in_word.offset_y;
        o_cmd.advance     = i_in_word.advance;
        o_cmd.color       = i_in_word.ink_color;
        o_cmd.final_byte  = 1'b0;
        if (r_remaining <= gbe_pkg::AREA_BITS'(gbe_pkg::BYTE_BITS)) begin
            w_count = r_remaining[gbe_pkg::COUNT_BITS-1:0];
        end
        // drop padding bits past the last glyph pixel
        o_cmd.bits  = i_in_word.bitmap_byte & ~(gbe_pkg::t_byte'('1) >> w_count);
        o_cmd.count = w_count;
        if (w_accept) begin
            case (i_in_word.operation)
                gbe_pkg::OP_HEADER: begin
                    o_push = 1'b1;
                    if (w_area == '0) begin
                        o_cmd.kind = gbe_pkg::CMD_EMPTY;
                        n_active   = 1'b0;
                    end else begin
                        o_cmd.kind  = gbe_pkg::CMD_HEAD;
                        n_active    = 1'b1;
                        n_remaining = w_area;
                    end
                end
                gbe_pkg::OP_BITMAP: begin
                    // stray bytes outside a glyph are dropped here
                    if (r_active) begin
                        o_push      = 1'b1;
                        n_remaining = r_remaining - gbe_pkg::AREA_BITS'(w_count);
                        if (r_remaining <= gbe_pkg::AREA_BITS'(gbe_pkg::BYTE_BITS)) begin
                            o_cmd.final_byte = 1'b1;
                            n_active         = 1'b0;
                        end
                    end
                end
                default: begin
                    o_push = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_remaining <= '0;
        end else begin
            r_active    <= n_active;
            r_remaining <= n_remaining;
        end
    end

endmodule

/* rtl/gbe_queue.sv */
// Short command queue between front and back.
module gbe_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  gbe_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output gbe_pkg::t_cmd o_head,
    output logic          o_empty
);

    localparam int IDX_BITS = $clog2(gbe_pkg::QUEUE_DEPTH);

    gbe_pkg::t_cmd       r_mem [gbe_pkg::QUEUE_DEPTH];
    logic [IDX_BITS:0]   r_wr_ptr;
    logic [IDX_BITS:0]   r_rd_ptr;

    assign o_empty = (r_wr_ptr == r_rd_ptr);
    assign o_full  = (r_wr_ptr[IDX_BITS] != r_rd_ptr[IDX_BITS])
                  && (r_wr_ptr[IDX_BITS-1:0] == r_rd_ptr[IDX_BITS-1:0]);
    assign o_head  = r_mem[r_rd_ptr[IDX_BITS-1:0]];

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            r_mem[r_wr_ptr[IDX_BITS-1:0]] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
        end else begin
            if (i_push && !o_full) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop && !o_empty) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

endmodule

/* rtl/gbe_back.sv */
// Back end: walks bitmap bits one per cycle while the result register is free, and drives the result register.
module gbe_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_empty,
    input  gbe_pkg::t_cmd      i_head,
    output logic               o_pop,
    input  gbe_pkg::t_byte     i_baseline,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output gbe_pkg::t_out_word o_out_word
);

    localparam int PAD = gbe_pkg::COORD_BITS - gbe_pkg::BYTE_BITS;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_BITS = 2'd1,
        S_DONE = 2'd2
    } t_state;

    t_state             r_state;
    gbe_pkg::t_coord    r_base_x;
    gbe_pkg::t_coord    r_base_y;
    gbe_pkg::t_coord    r_next_pen;
    gbe_pkg::t_byte     r_width;
    gbe_pkg::t_color    r_color;
    gbe_pkg::t_byte     r_bits;
    gbe_pkg::t_count    r_count;
    logic               r_final;
    gbe_pkg::t_byte     r_col;
    gbe_pkg::t_byte     r_row;
    logic               r_out_valid;
    gbe_pkg::t_out_word r_out_word;

    logic               w_slot_free;
    logic               w_emit;
    gbe_pkg::t_coord    w_px;
    gbe_pkg::t_coord    w_py;

    assign w_slot_free = !r_out_valid || i_out_ready;
    assign w_px = r_base_x + {{PAD{1'b0}}, r_col};
    assign w_py = r_base_y + {{PAD{1'b0}}, r_row} + {{PAD{1'b0}}, i_baseline};
    assign o_pop = (r_state == S_IDLE) && !i_empty
                && ((i_head.kind != gbe_pkg::CMD_EMPTY) || w_slot_free);
    // load a result word this cycle
    assign w_emit = (o_pop && (i_head.kind == gbe_pkg::CMD_EMPTY))
                 || ((r_state == S_BITS) && w_slot_free && r_bits[gbe_pkg::BYTE_BITS-1])
                 || ((r_state == S_DONE) && w_slot_free);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_col       <= '0;
            r_row       <= '0;
        end else begin
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (o_pop) begin
                        case (i_head.kind)
                            gbe_pkg::CMD_HEAD: begin
                                r_base_x   <= i_head.pen_x
                                            + {{PAD{i_head.off_x[7]}}, i_head.off_x};
                                r_base_y   <= i_head.pen_y
                                            + {{PAD{i_head.off_y[7]}}, i_head.off_y};
                                r_next_pen <= i_head.pen_x + {{PAD{1'b0}}, i_head.advance};
                                r_width    <= i_head.width;
                                r_color    <= i_head.color;
                                r_col      <= '0;
                                r_row      <= '0;
                            end
                            gbe_pkg::CMD_EMPTY: begin
                                r_out_word.kind        <= gbe_pkg::KIND_DONE;
                                r_out_word.pixel_x     <= '0;
                                r_out_word.pixel_y     <= '0;
                                r_out_word.pixel_value <= '0;
                                r_out_word.next_pen_x  <= i_head.pen_x
                                                        + {{PAD{1'b0}}, i_head.advance};
                                r_out_word.last        <= 1'b1;
                            end
                            gbe_pkg::CMD_BYTE: begin
                                r_bits  <= i_head.bits;
                                r_count <= i_head.count;
                                r_final <= i_head.final_byte;
                                r_state <= S_BITS;
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_BITS: begin
                    if (w_slot_free) begin
                        if (r_bits[gbe_pkg::BYTE_BITS-1]) begin
                            r_out_word.kind        <= gbe_pkg::KIND_PIXEL;
                            r_out_word.pixel_x     <= w_px;
                            r_out_word.pixel_y     <= w_py;
                            r_out_word.pixel_value <= r_color;
                            r_out_word.next_pen_x  <= '0;
                            r_out_word.last        <= (r_bits[gbe_pkg::BYTE_BITS-2:0] == '0)
                                                   && !r_final;
                        end
                        r_bits  <= r_bits << 1;
                        r_count <= r_count - 1'b1;
                        if (r_col + 1'b1 == r_width) begin
                            r_col <= '0;
                            r_row <= r_row + 1'b1;
                        end else begin
                            r_col <= r_col + 1'b1;
                        end
                        if (r_count == gbe_pkg::t_count'(1)) begin
                            r_state <= r_final ? S_DONE : S_IDLE;
                        end
                    end
                end
                S_DONE: begin
                    if (w_slot_free) begin
                        r_out_word.kind        <= gbe_pkg::KIND_DONE;
                        r_out_word.pixel_x     <= '0;
                        r_out_word.pixel_y     <= '0;
                        r_out_word.pixel_value <= '0;
                        r_out_word.next_pen_x  <= r_next_pen;
                        r_out_word.last        <= 1'b1;
                        r_col                  <= '0;
                        r_row                  <= '0;
                        r_state                <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

/* rtl/glyph_bitmap_expander.sv */
// Top level of the glyph bitmap expander: register port, front, queue and back.
//
//  channel   direction  handshake                      word
//  in        to block   i_in_valid / o_in_ready        gbe_pkg::t_in_word
//  out       from block o_out_valid / i_out_ready      gbe_pkg::t_out_word
//  config    to block   psel/penable/pwrite, pready=1  baseline at address 0
//
// A bitmap byte is popped from the queue in the idle state, then the bit-walking
// back end steps through each glyph pixel it holds; the last byte of a glyph adds
// the finished word. A header is popped in the idle state. The front takes a word
// every cycle while the four-entry queue has room, so headers and stray bytes
// pass at full speed.
// Synchronous active-low reset clears control state; no clearing pass is needed.
// A stalled output holds the back end; the queue absorbs the front meanwhile.
module glyph_bitmap_expander (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // input words
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  gbe_pkg::t_in_word                  i_in_word,
    // result words
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output gbe_pkg::t_out_word                 o_out_word,
    // register port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [gbe_pkg::ADDR_BITS-1:0]      paddr,
    input  logic [gbe_pkg::DATA_BITS-1:0]      pwdata,
    output logic [gbe_pkg::DATA_BITS-1:0]      prdata,
    output logic                               pready
);

    gbe_pkg::t_byte r_baseline;
    logic           w_reg_hit;
    logic           w_push;
    logic           w_full;
    logic           w_pop;
    logic           w_empty;
    gbe_pkg::t_cmd  w_push_cmd;
    gbe_pkg::t_cmd  w_head_cmd;

    // register 0 sits at byte address 0; word index is paddr[2]
    assign pready    = 1'b1;
    assign w_reg_hit = (paddr[2] == gbe_pkg::REG_BASELINE);
    assign prdata    = w_reg_hit
                     ? {{(gbe_pkg::DATA_BITS - gbe_pkg::BYTE_BITS){1'b0}}, r_baseline}
                     : '0;

    // baseline is added to every row
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_baseline <= '0;
        end else if (psel && penable && pwrite && w_reg_hit) begin
            r_baseline <= pwdata[gbe_pkg::BYTE_BITS-1:0];
        end
    end

    // front: classify headers, budget the glyph's pixels, drop stray bytes
    gbe_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_word  (i_in_word),
        .o_push     (w_push),
        .o_cmd      (w_push_cmd),
        .i_full     (w_full)
    );

    // decouple front and back so each stalls on its own
    gbe_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_head  (w_head_cmd),
        .o_empty (w_empty)
    );

    // back: one bit per cycle while the result register is free, pixel writes and finished words
    gbe_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (w_empty),
        .i_head      (w_head_cmd),
        .o_pop       (w_pop),
        .i_baseline  (r_baseline),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

endmodule

/* bench/tb_glyph_bitmap_expander.sv */
// Self-checking testbench for the glyph bitmap expander: directed and random glyph streams.
module tb_glyph_bitmap_expander;
    timeunit 1ns;
    timeprecision 1ps;

    // Margin for the four queue entries to pass through the back end.
    localparam int SETTLE_CYCLES = 64;
    // Receiver hold-off long enough to fill the internal queue and stall the input.
    localparam int LONG_HOLD     = 300;

    logic                          i_clk       = 1'b0;
    logic                          i_rst_n     = 1'b0;
    logic                          i_in_valid  = 1'b0;
    logic                          o_in_ready;
    gbe_pkg::t_in_word             i_in_word   = '0;
    logic                          o_out_valid;
    logic                          i_out_ready = 1'b0;
    gbe_pkg::t_out_word            o_out_word;
    logic                          psel        = 1'b0;
    logic                          penable     = 1'b0;
    logic                          pwrite      = 1'b0;
    logic [gbe_pkg::ADDR_BITS-1:0] paddr       = '0;
    logic [gbe_pkg::DATA_BITS-1:0] pwdata      = '0;
    logic [gbe_pkg::DATA_BITS-1:0] prdata;
    logic                          pready;

    glyph_bitmap_expander u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Expected behavior: a private copy of the glyph state and baseline.
    // ------------------------------------------------------------------
    logic [7:0]      baseline_q = '0;
    logic            glyph_open = 1'b0;
    gbe_pkg::t_byte  row_at     = '0;
    gbe_pkg::t_byte  col_at     = '0;
    gbe_pkg::t_coord org_x      = '0;
    gbe_pkg::t_coord org_y      = '0;
    gbe_pkg::t_byte  size_w     = '0;
    gbe_pkg::t_byte  size_h     = '0;
    logic [7:0]      off_x      = '0;
    logic [7:0]      off_y      = '0;
    gbe_pkg::t_byte  adv_q      = '0;
    gbe_pkg::t_color ink_q      = '0;

    gbe_pkg::t_out_word writes_due[$];     // pixel writes and finish words still to come
    gbe_pkg::t_in_word  pending_words[$];  // words waiting for the driver
    int         err_count  = 0;
    int         idle_odds  = 0;    // 0: no idling, else one burst per idle_odds words
    int         hold_asks  = 0;    // bumped by the sequencer to request a long hold

    function automatic gbe_pkg::t_out_word finish_word();
        gbe_pkg::t_out_word w;
        w            = '0;
        w.kind       = gbe_pkg::KIND_DONE;
        w.next_pen_x = org_x + gbe_pkg::t_coord'(adv_q);
        return w;
    endfunction

    // Advance the glyph state by one accepted word and queue what it yields.
    task automatic expand_word(input gbe_pkg::t_in_word wd);
        gbe_pkg::t_out_word batch[$];
        gbe_pkg::t_out_word px;
        gbe_pkg::t_byte     bits;
        if (wd.operation == gbe_pkg::OP_HEADER) begin
            org_x  = wd.pen_x;
            org_y  = wd.pen_y;
            size_w = wd.glyph_width;
            size_h = wd.glyph_height;
            off_x  = wd.offset_x;
            off_y  = wd.offset_y;
            adv_q  = wd.advance;
            ink_q  = wd.ink_color;
            row_at = '0;
            col_at = '0;
            // Empty glyph: finish at once, nothing stays open.
            if (size_w == 0 || size_h == 0) begin
                glyph_open = 1'b0;
                batch.push_back(finish_word());
            end else begin
                glyph_open = 1'b1;
            end
        end else if (glyph_open) begin
            bits = wd.bitmap_byte;
            for (int b = 7; b >= 0; b--) begin
                // Padding bits after the last glyph pixel are dropped.
                if (row_at >= size_h)
                    break;
                if (bits[b]) begin
                    px             = '0;
                    px.kind        = gbe_pkg::KIND_PIXEL;
                    px.pixel_x     = org_x + gbe_pkg::t_coord'(col_at)
                                     + {{8{off_x[7]}}, off_x};
                    px.pixel_y     = org_y + gbe_pkg::t_coord'(row_at)
                                     + {{8{off_y[7]}}, off_y}
                                     + gbe_pkg::t_coord'(baseline_q);
                    px.pixel_value = ink_q;
                    batch.push_back(px);
                end
                col_at++;
                if (col_at >= size_w) begin
                    col_at = '0;
                    row_at++;
                end
            end
            if (row_at >= size_h) begin
                glyph_open = 1'b0;
                row_at     = '0;
                col_at     = '0;
                batch.push_back(finish_word());
            end
        end
        // A stray byte with no glyph open yields nothing.
        if (batch.size() > 0)
            batch[batch.size()-1].last = 1'b1;
        foreach (batch[i])
            writes_due.push_back(batch[i]);
    endtask

    task automatic report_error(input string msg);
        $display("%0t ns: mismatch: %s", $time, msg);
        err_count++;
    endtask

    task automatic check_field(input string name, input logic [95:0] got,
                               input logic [95:0] want);
        if (got !== want)
            report_error($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    // ------------------------------------------------------------------
    // Input side: note acceptance at the rising edge, drive at the falling.
    // ------------------------------------------------------------------
    bit word_taken = 1'b0;
    int gap_left   = 0;

    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_ready) begin
            expand_word(i_in_word);
            word_taken = 1'b1;
        end
    end

    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !word_taken) begin
                // hold: word still on offer
            end else if (gap_left > 0) begin
                gap_left--;
                i_in_valid <= 1'b0;
            end else if (pending_words.size() == 0) begin
                i_in_valid <= 1'b0;
            end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
                gap_left = $urandom_range(1, 15) - 1;
                i_in_valid <= 1'b0;
            end else begin
                i_in_valid <= 1'b1;
                i_in_word  <= pending_words.pop_front();
            end
            word_taken = 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Output side: random stall bursts plus an occasional long hold.
    // ------------------------------------------------------------------
    int hold_served = 0;
    int hold_left   = 0;
    int stall_left  = 0;

    always @(negedge i_clk) begin
        if (hold_served != hold_asks) begin
            hold_served = hold_asks;
            hold_left   = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
            stall_left = $urandom_range(1, 15) - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // Compare every delivered word with the oldest one expected.
    always @(posedge i_clk) begin : out_monitor
        gbe_pkg::t_out_word want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (writes_due.size() == 0) begin
                report_error($sformatf("result word %0h with none expected", o_out_word));
            end else begin
                want = writes_due.pop_front();
                check_field("kind",        o_out_word.kind,        want.kind);
                check_field("pixel_x",     o_out_word.pixel_x,     want.pixel_x);
                check_field("pixel_y",     o_out_word.pixel_y,     want.pixel_y);
                check_field("pixel_value", o_out_word.pixel_value, want.pixel_value);
                check_field("next_pen_x",  o_out_word.next_pen_x,  want.next_pen_x);
                check_field("last",        o_out_word.last,        want.last);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus builders.
    // ------------------------------------------------------------------
    function automatic gbe_pkg::t_in_word header_word(gbe_pkg::t_coord px,
                                                      gbe_pkg::t_coord py,
                                                      gbe_pkg::t_byte w, gbe_pkg::t_byte h,
                                                      logic [7:0] ox, logic [7:0] oy,
                                                      gbe_pkg::t_byte adv,
                                                      gbe_pkg::t_color ink);
        gbe_pkg::t_in_word wd;
        wd              = '0;
        wd.operation    = gbe_pkg::OP_HEADER;
        wd.pen_x        = px;
        wd.pen_y        = py;
        wd.glyph_width  = w;
        wd.glyph_height = h;
        wd.offset_x     = ox;
        wd.offset_y     = oy;
        wd.advance      = adv;
        wd.ink_color    = ink;
        wd.bitmap_byte  = gbe_pkg::t_byte'($urandom);  // ignored on a header
        return wd;
    endfunction

    function automatic gbe_pkg::t_in_word random_header(gbe_pkg::t_byte w, gbe_pkg::t_byte h);
        return header_word(gbe_pkg::t_coord'($urandom), gbe_pkg::t_coord'($urandom), w, h,
                           8'($urandom), 8'($urandom), gbe_pkg::t_byte'($urandom),
                           gbe_pkg::t_color'($urandom));
    endfunction

    // Bitmap word with junk in every header field.
    function automatic gbe_pkg::t_in_word bitmap_word(gbe_pkg::t_byte bits);
        logic [127:0]      noise;
        gbe_pkg::t_in_word wd;
        noise          = {$urandom, $urandom, $urandom, $urandom};
        wd             = noise[$bits(gbe_pkg::t_in_word)-1:0];
        wd.operation   = gbe_pkg::OP_BITMAP;
        wd.bitmap_byte = bits;
        return wd;
    endfunction

    function automatic gbe_pkg::t_byte pick_bits();
        int r;
        r = $urandom_range(0, 9);
        if (r < 3)
            return 8'hFF;
        if (r == 3)
            return 8'h00;
        return gbe_pkg::t_byte'($urandom);
    endfunction

    // Queue mostly whole glyphs with random content; mix in strays, empty
    // glyphs and glyphs cut short by the next header.
    task automatic queue_glyphs(input int target);
        int             made;
        int             r;
        int             s;
        int             need;
        int             keep;
        bit             open;
        gbe_pkg::t_byte w;
        gbe_pkg::t_byte h;
        made = 0;
        open = 1'b0;
        while (made < target) begin
            r = $urandom_range(0, 99);
            if (r < 8 && !open) begin
                pending_words.push_back(bitmap_word(pick_bits()));
            end else if (r < 16) begin
                w = $urandom_range(0, 1) ? gbe_pkg::t_byte'(0) : gbe_pkg::t_byte'($urandom);
                h = (w == 0) ? gbe_pkg::t_byte'($urandom) : gbe_pkg::t_byte'(0);
                pending_words.push_back(random_header(w, h));
                made++;
                open = 1'b0;
            end else begin
                s = $urandom_range(0, 19);
                if (s == 0) begin
                    w = 8'd255;
                    h = gbe_pkg::t_byte'($urandom_range(1, 2));
                end else if (s == 1) begin
                    w = gbe_pkg::t_byte'($urandom_range(1, 3));
                    h = 8'd255;
                end else if (s == 2) begin
                    w = gbe_pkg::t_byte'($urandom_range(1, 255));
                    h = 8'd1;
                end else begin
                    w = gbe_pkg::t_byte'($urandom_range(1, 12));
                    h = gbe_pkg::t_byte'($urandom_range(1, 12));
                end
                need = (int'(w) * int'(h) + 7) / 8;
                keep = (r < 26) ? $urandom_range(0, need - 1) : need;
                pending_words.push_back(random_header(w, h));
                repeat (keep)
                    pending_words.push_back(bitmap_word(pick_bits()));
                made += 1 + keep;
                open  = (keep < need);
            end
        end
        // Close with an empty glyph so no glyph stays open across a register write.
        pending_words.push_back(random_header(8'd0, gbe_pkg::t_byte'($urandom)));
    endtask

    // Wait until every word is taken and every result has come, then let
    // any word that yields nothing clear the block.
    task automatic drain();
        while (pending_words.size() != 0 || i_in_valid || writes_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write the baseline register, then read it back.
    task automatic write_baseline(input logic [7:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {gbe_pkg::REG_BASELINE, 2'b00};
        pwdata  <= {24'd0, value};
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        baseline_q = value;
        @(negedge i_clk);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata !== {24'd0, value})
            report_error($sformatf("baseline readback %0h want %0h", prdata, value));
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Sequencer.
    // ------------------------------------------------------------------
    initial begin
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, at a baseline of 128.
        write_baseline(8'd128);
        idle_odds = 5;
        // stray byte with no glyph open
        pending_words.push_back(bitmap_word(8'hFF));
        // empty glyphs: zero width, then zero height; pen plus advance wraps
        pending_words.push_back(header_word(16'hFFFF, 16'h0000, 8'd0, 8'd5, 8'h00, 8'h00,
                                            8'hFF, 32'h0));
        pending_words.push_back(header_word(16'h0000, 16'hFFFF, 8'd5, 8'd0, 8'h00, 8'h00,
                                            8'h00, 32'h0));
        // full byte, most negative offsets, coordinates wrap
        pending_words.push_back(header_word(16'hFFF0, 16'hFFF8, 8'd8, 8'd1, 8'h80, 8'h80,
                                            8'd1, 32'hFFFF_FFFF));
        pending_words.push_back(bitmap_word(8'hFF));
        // most positive offsets, padding bits in the final byte
        pending_words.push_back(header_word(16'h1234, 16'hFFFF, 8'd3, 8'd2, 8'h7F, 8'h7F,
                                            8'd10, 32'hA5A5_A5A5));
        pending_words.push_back(bitmap_word(8'hFF));
        // largest glyph abandoned by a new header
        pending_words.push_back(header_word(16'd100, 16'd200, 8'd255, 8'd255, 8'h00, 8'h00,
                                            8'd7, 32'h1));
        pending_words.push_back(bitmap_word(8'h00));
        pending_words.push_back(bitmap_word(8'hAA));
        pending_words.push_back(header_word(16'd5, 16'd5, 8'd1, 8'd1, 8'hFF, 8'hFF,
                                            8'd255, 32'h0));
        pending_words.push_back(bitmap_word(8'h80));
        // rows running across a byte boundary
        pending_words.push_back(header_word(16'd0, 16'd0, 8'd3, 8'd3, 8'h00, 8'h00,
                                            8'd3, 32'h1234_5678));
        pending_words.push_back(bitmap_word(8'hFF));
        pending_words.push_back(bitmap_word(8'h80));
        // final byte with no ink: finish word only
        pending_words.push_back(header_word(16'd50, 16'd60, 8'd2, 8'd2, 8'h05, 8'hFB,
                                            8'd9, 32'hDEAD_BEEF));
        pending_words.push_back(bitmap_word(8'h00));
        // only padding set in the final byte, then a stray after completion
        pending_words.push_back(header_word(16'd0, 16'd0, 8'd1, 8'd1, 8'h00, 8'h00,
                                            8'd0, 32'h0));
        pending_words.push_back(bitmap_word(8'h7F));
        pending_words.push_back(bitmap_word(8'hFF));
        drain();

        // Random part with a long receiver hold at its start; the sender keeps
        // offering so the block fills and stalls its input.
        write_baseline(8'd0);
        idle_odds = 4;
        hold_asks++;
        queue_glyphs(70);
        drain();

        write_baseline(8'($urandom_range(1, 127)));
        idle_odds = 12;
        queue_glyphs(70);
        drain();

        write_baseline(8'd128);
        idle_odds = 6;
        queue_glyphs(60);
        drain();

        // Last stretch at full speed on both sides.
        write_baseline(8'd1);
        idle_odds = 0;
        queue_glyphs(50);
        drain();

        if (err_count == 0)
            $display("tb_glyph_bitmap_expander: done, clean");
        else
            $display("tb_glyph_bitmap_expander: done, errors");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #5_000_000;
        $display("tb_glyph_bitmap_expander: done, errors");
        $finish;
    end

endmodule
